@@ sv/dqps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqps_pkg
// Shared types and constants for the dual queue priority scheduler.
// ----------------------------------------------------------------------------
package dqps_pkg;

    localparam int ID_W    = 10;
    localparam int FUNC_W  = 2;
    localparam int DEPTH_W = 4;
    localparam int CNT_W   = 16;

    localparam logic [FUNC_W-1:0] FUNC_ENQ_HI = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ENQ_LO = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd2;

    typedef enum logic [2:0] {
        ST_ACCEPTED  = 3'd0,
        ST_REFUSED   = 3'd1,
        ST_SERVED_HI = 3'd2,
        ST_SERVED_LO = 3'd3,
        ST_IDLE      = 3'd4
    } t_status;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ID_W-1:0]   item_id;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic [ID_W-1:0]    served_id;
        logic [DEPTH_W-1:0] high_depth;
        logic [DEPTH_W-1:0] low_depth;
        logic [CNT_W-1:0]   high_served_total;
        logic [CNT_W-1:0]   low_served_total;
        logic [CNT_W-1:0]   refused_total;
        logic [CNT_W-1:0]   idle_total;
    } t_out_item;

    typedef struct packed {
        logic push;
        logic pop;
    } t_fifo_ctl;

    typedef struct packed {
        logic empty;
        logic full;
    } t_fifo_sts;

endpackage

@@ sv/dqps_satcnt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqps_satcnt
// Saturating event counter; reports the value after this cycle's update.
// ----------------------------------------------------------------------------
module dqps_satcnt (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_inc,
    output logic [dqps_pkg::CNT_W-1:0] o_cnt_nxt
);

    logic [dqps_pkg::CNT_W-1:0] r_cnt;
    logic [dqps_pkg::CNT_W-1:0] n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_inc && (r_cnt != '1)) begin
            n_cnt = r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign o_cnt_nxt = n_cnt;

endmodule

@@ sv/dqps_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqps_fifo
// Circular ID queue with a registered front entry; the storage array is
// read one entry ahead on each pop.
// ----------------------------------------------------------------------------
module dqps_fifo #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dqps_pkg::t_fifo_ctl           i_ctl,
    input  logic [dqps_pkg::ID_W-1:0]     i_id,
    output dqps_pkg::t_fifo_sts           o_sts,
    output logic [dqps_pkg::ID_W-1:0]     o_front,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] o_fill_nxt
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);

    logic [dqps_pkg::ID_W-1:0] mem [QUEUE_DEPTH];
    logic [AW-1:0]             r_head;
    logic [AW-1:0]             r_tail;
    logic [FW-1:0]             r_fill;
    logic [dqps_pkg::ID_W-1:0] r_front;
    logic [AW-1:0]             n_head;
    logic [AW-1:0]             n_tail;
    logic [FW-1:0]             n_fill;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        logic [AW-1:0] q;
        q = (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
        return q;
    endfunction

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_fill = r_fill;
        if (i_ctl.push) begin
            n_tail = ptr_inc(r_tail);
            n_fill = r_fill + 1'b1;
        end else if (i_ctl.pop) begin
            n_head = ptr_inc(r_head);
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            mem[r_tail] <= i_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push && (r_fill == '0)) begin
            r_front <= i_id;
        end else if (i_ctl.pop && (r_fill > FW'(1))) begin
            r_front <= mem[n_head];
        end
    end

    assign o_sts.empty = (r_fill == '0);
    assign o_sts.full  = (r_fill == FW'(QUEUE_DEPTH));
    assign o_front     = r_front;
    assign o_fill_nxt  = n_fill;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(QUEUE_DEPTH))
        else $error("queue fill above depth");

endmodule

@@ sv/dual_queue_priority_scheduler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_queue_priority_scheduler
// Two ID queues served in strict priority, with saturating event totals.
// The result is registered at the edge that takes the item.
// Throughput: 1 transaction per cycle, set by the single output register; a stalled output holds the input.
// Reset clears queue pointers, fills, totals and the output valid.
// Queue storage is not cleared; entries are read only after being written.
// ----------------------------------------------------------------------------
module dual_queue_priority_scheduler #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  dqps_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output dqps_pkg::t_out_item o_out_data
);

    localparam int FW = $clog2(QUEUE_DEPTH + 1);

    logic                      in_acc;
    logic                      is_enq_hi;
    logic                      is_enq_lo;
    logic                      is_tick;
    dqps_pkg::t_fifo_ctl       hi_ctl;
    dqps_pkg::t_fifo_ctl       lo_ctl;
    dqps_pkg::t_fifo_sts       hi_sts;
    dqps_pkg::t_fifo_sts       lo_sts;
    logic [dqps_pkg::ID_W-1:0] hi_front;
    logic [dqps_pkg::ID_W-1:0] lo_front;
    logic [FW-1:0]             hi_fill_nxt;
    logic [FW-1:0]             lo_fill_nxt;
    logic                      refuse;
    logic                      idle;
    logic [dqps_pkg::CNT_W-1:0] hi_cnt_nxt;
    logic [dqps_pkg::CNT_W-1:0] lo_cnt_nxt;
    logic [dqps_pkg::CNT_W-1:0] ref_cnt_nxt;
    logic [dqps_pkg::CNT_W-1:0] idle_cnt_nxt;
    dqps_pkg::t_out_item       n_out;
    dqps_pkg::t_out_item       r_out;
    logic                      r_out_valid;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign is_enq_hi = (i_in_data.func == dqps_pkg::FUNC_ENQ_HI);
    assign is_enq_lo = (i_in_data.func == dqps_pkg::FUNC_ENQ_LO);
    assign is_tick   = !is_enq_hi && !is_enq_lo;

    assign hi_ctl.push = in_acc && is_enq_hi && !hi_sts.full;
    assign lo_ctl.push = in_acc && is_enq_lo && !lo_sts.full;
    assign hi_ctl.pop  = in_acc && is_tick && !hi_sts.empty;
    assign lo_ctl.pop  = in_acc && is_tick && hi_sts.empty && !lo_sts.empty;
    assign refuse      = in_acc && ((is_enq_hi && hi_sts.full) || (is_enq_lo && lo_sts.full));
    assign idle        = in_acc && is_tick && hi_sts.empty && lo_sts.empty;

    dqps_fifo #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_hi_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (hi_ctl),
        .i_id       (i_in_data.item_id),
        .o_sts      (hi_sts),
        .o_front    (hi_front),
        .o_fill_nxt (hi_fill_nxt)
    );

    dqps_fifo #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_lo_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (lo_ctl),
        .i_id       (i_in_data.item_id),
        .o_sts      (lo_sts),
        .o_front    (lo_front),
        .o_fill_nxt (lo_fill_nxt)
    );

    dqps_satcnt u_hi_cnt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_inc(hi_ctl.pop), .o_cnt_nxt(hi_cnt_nxt)
    );

    dqps_satcnt u_lo_cnt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_inc(lo_ctl.pop), .o_cnt_nxt(lo_cnt_nxt)
    );

    dqps_satcnt u_ref_cnt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_inc(refuse), .o_cnt_nxt(ref_cnt_nxt)
    );

    dqps_satcnt u_idle_cnt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_inc(idle), .o_cnt_nxt(idle_cnt_nxt)
    );

    always_comb begin
        n_out.served_id = '0;
        priority if (refuse) begin
            n_out.status = dqps_pkg::ST_REFUSED;
        end else if (hi_ctl.pop) begin
            n_out.status    = dqps_pkg::ST_SERVED_HI;
            n_out.served_id = hi_front;
        end else if (lo_ctl.pop) begin
            n_out.status    = dqps_pkg::ST_SERVED_LO;
            n_out.served_id = lo_front;
        end else if (idle) begin
            n_out.status = dqps_pkg::ST_IDLE;
        end else begin
            n_out.status = dqps_pkg::ST_ACCEPTED;
        end
        n_out.high_depth        = dqps_pkg::DEPTH_W'(hi_fill_nxt);
        n_out.low_depth         = dqps_pkg::DEPTH_W'(lo_fill_nxt);
        n_out.high_served_total = hi_cnt_nxt;
        n_out.low_served_total  = lo_cnt_nxt;
        n_out.refused_total     = ref_cnt_nxt;
        n_out.idle_total        = idle_cnt_nxt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_hi_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && is_tick && !hi_sts.empty) |=> (r_out.status == dqps_pkg::ST_SERVED_HI))
        else $error("tick with high entries not served from high queue");

    a_full_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && is_enq_lo && lo_sts.full) |=> (r_out.status == dqps_pkg::ST_REFUSED))
        else $error("enqueue into full low queue not refused");

    a_one_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(hi_ctl.pop && lo_ctl.pop) && !(hi_ctl.push && lo_ctl.push))
        else $error("both queues updated by one transaction");

endmodule
